[sv/bbc_pkg.sv]
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the bracket balance checker
// Holds the bracket kind and verdict codes, the stack control and status
// bundles, and the character decode functions.
// ----------------------------------------------------------------------------
package bbc_pkg;

  // Bracket kind held in each stack cell; zero means no bracket.
  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_PAREN  = 2'd1,
    KIND_SQUARE = 2'd2,
    KIND_CURLY  = 2'd3
  } kind_t;

  // Verdict codes reported in the status field.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_CLOSER = 3'd1,
    ST_UNCLOSED   = 3'd2,
    ST_EMPTY_PAIR = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  // Character codes of the six brackets.
  localparam logic [7:0] CHR_LPAREN = 8'h28;
  localparam logic [7:0] CHR_RPAREN = 8'h29;
  localparam logic [7:0] CHR_LSQUARE = 8'h5B;
  localparam logic [7:0] CHR_RSQUARE = 8'h5D;
  localparam logic [7:0] CHR_LCURLY = 8'h7B;
  localparam logic [7:0] CHR_RCURLY = 8'h7D;

  // Field widths of the result.
  localparam int STATUS_W = 3;
  localparam int POS_W = 16;

  // Control bundle driven into the stack.
  typedef struct packed {
    logic  clr;
    logic  push;
    logic  pop;
    kind_t kind;
  } stk_op_t;

  // Status bundle returned by the stack.
  typedef struct packed {
    logic  empty;
    logic  single;
    logic  full;
    kind_t top;
  } stk_stat_t;

  // Kind of an opening bracket, or none.
  function automatic kind_t opener_kind(input logic [7:0] ch);
    kind_t k;
    k = KIND_NONE;
    if (ch == CHR_LPAREN) k = KIND_PAREN;
    else if (ch == CHR_LSQUARE) k = KIND_SQUARE;
    else if (ch == CHR_LCURLY) k = KIND_CURLY;
    return k;
  endfunction

  // Kind of a closing bracket, or none.
  function automatic kind_t closer_kind(input logic [7:0] ch);
    kind_t k;
    k = KIND_NONE;
    if (ch == CHR_RPAREN) k = KIND_PAREN;
    else if (ch == CHR_RSQUARE) k = KIND_SQUARE;
    else if (ch == CHR_RCURLY) k = KIND_CURLY;
    return k;
  endfunction

endpackage

[sv/bracket_balance_checker_top.sv]
// Bracket balance checker: one character accepted per cycle while the skid
// register is empty. The verdict is registered in the output register, or in
// the skid register while the output is stalled. The push, pop and top compare
// in the cell chain set the rate; the skid register keeps input flowing while
// one verdict waits in the output register. Reset (rst_n low, synchronous)
// clears count, error, position and valid flags; stack cell contents are not reset.
// ----------------------------------------------------------------------------
// bracket_balance_checker_top: streaming balanced bracket checker
// Tracks bracket nesting over a string, keeps the first error and its
// position, and gives one verdict on the last character of each string.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top #(
  parameter int STACK_DEPTH = 64,
  parameter int INDEX_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] status, [18:3] error_position, [23:19] zero
);

  localparam int RES_W = bbc_pkg::STATUS_W + bbc_pkg::POS_W;

  // Checker state.
  bbc_pkg::status_t       err_r, err_nxt;
  logic [INDEX_BITS-1:0]  fidx_r, fidx_nxt;
  logic [INDEX_BITS-1:0]  cidx_r, cidx_nxt;
  bbc_pkg::kind_t         prev_r, prev_nxt;

  // Output register and skid register.
  logic             ov_r, ov_nxt;
  logic [RES_W-1:0] od_r, od_nxt;
  logic             sv_r, sv_nxt;
  logic [RES_W-1:0] sd_r, sd_nxt;

  bbc_pkg::stk_op_t   op;
  bbc_pkg::stk_stat_t stat;
  bbc_pkg::kind_t     ok_k, ck_k;
  logic               acc;
  logic               left_open;
  logic [31:0]        fidx_ext;
  logic [RES_W-1:0]   res;

  assign in_tready = !sv_r;
  assign acc = in_tvalid && in_tready;
  assign ok_k = bbc_pkg::opener_kind(in_tdata);
  assign ck_k = bbc_pkg::closer_kind(in_tdata);

  bbc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .stat  (stat)
  );

  // Per-character check: push, pop and compare against the top cell.
  always_comb begin
    err_nxt  = err_r;
    fidx_nxt = fidx_r;
    prev_nxt = prev_r;
    cidx_nxt = cidx_r;
    // The stack empties together with the verdict.
    op.clr   = acc && in_tlast;
    op.push  = 1'b0;
    op.pop   = 1'b0;
    op.kind  = ok_k;
    if (acc) begin
      if (err_r == bbc_pkg::ST_OK) begin
        if (ok_k != bbc_pkg::KIND_NONE) begin
          if (!stat.full) begin
            op.push = 1'b1;
          end else begin
            err_nxt  = bbc_pkg::ST_OVERFLOW;
            fidx_nxt = cidx_r;
          end
        end else if (ck_k != bbc_pkg::KIND_NONE) begin
          if (stat.empty) begin
            err_nxt  = bbc_pkg::ST_BAD_CLOSER;
            fidx_nxt = cidx_r;
          end else begin
            op.pop = 1'b1;
            if (stat.top != ck_k) begin
              err_nxt  = bbc_pkg::ST_BAD_CLOSER;
              fidx_nxt = cidx_r;
            end else if (prev_r == ck_k) begin
              err_nxt  = bbc_pkg::ST_EMPTY_PAIR;
              fidx_nxt = cidx_r;
            end
          end
        end
      end
      prev_nxt = ok_k;
      if (cidx_r != '1) begin
        cidx_nxt = cidx_r + INDEX_BITS'(1);
      end
    end
    // Stack still holds an opener once this character is applied.
    left_open = op.push || (!stat.empty && !(op.pop && stat.single));
    if (acc && in_tlast && err_nxt == bbc_pkg::ST_OK && left_open) begin
      err_nxt  = bbc_pkg::ST_UNCLOSED;
      fidx_nxt = cidx_r;
    end
  end

  // Verdict payload; position is zero when the string is balanced.
  assign fidx_ext = 32'(fidx_nxt);
  assign res = (err_nxt == bbc_pkg::ST_OK) ? '0 : {fidx_ext[bbc_pkg::POS_W-1:0], err_nxt};

  // Output register with skid stage.
  always_comb begin
    ov_nxt = ov_r;
    od_nxt = od_r;
    sv_nxt = sv_r;
    sd_nxt = sd_r;
    if (!ov_r || out_tready) begin
      if (sv_r) begin
        ov_nxt = 1'b1;
        od_nxt = sd_r;
        sv_nxt = 1'b0;
      end else begin
        ov_nxt = acc && in_tlast;
        od_nxt = res;
      end
    end else if (acc && in_tlast) begin
      sv_nxt = 1'b1;
      sd_nxt = res;
    end
  end

  // State registers; the verdict clears all string state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r  <= bbc_pkg::ST_OK;
      fidx_r <= '0;
      cidx_r <= '0;
      prev_r <= bbc_pkg::KIND_NONE;
      ov_r   <= 1'b0;
      sv_r   <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
      if (acc && in_tlast) begin
        err_r  <= bbc_pkg::ST_OK;
        fidx_r <= '0;
        cidx_r <= '0;
        prev_r <= bbc_pkg::KIND_NONE;
      end else begin
        err_r  <= err_nxt;
        fidx_r <= fidx_nxt;
        cidx_r <= cidx_nxt;
        prev_r <= prev_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    sd_r <= sd_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {(24 - RES_W)'(0), od_r};

endmodule

[sv/bbc_cell.sv]
// ----------------------------------------------------------------------------
// bbc_cell: one entry of the shifting bracket stack
// On a push the cell takes the kind of its upper neighbor, on a pop the kind
// of its lower neighbor; otherwise it holds.
// ----------------------------------------------------------------------------
module bbc_cell (
  input  logic             clk,
  input  bbc_pkg::stk_op_t op,
  input  bbc_pkg::kind_t   up_kind,
  input  bbc_pkg::kind_t   dn_kind,
  output bbc_pkg::kind_t   kind_q
);

  bbc_pkg::kind_t kind_r;
  bbc_pkg::kind_t kind_nxt;

  // Shift toward the bottom on push, toward the top on pop.
  always_comb begin
    kind_nxt = kind_r;
    if (op.push) begin
      kind_nxt = up_kind;
    end else if (op.pop) begin
      kind_nxt = dn_kind;
    end
  end

  // Payload only; contents are undefined until pushed.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
  end

  assign kind_q = kind_r;

endmodule

[sv/bbc_stack.sv]
// ----------------------------------------------------------------------------
// bbc_stack: bounded bracket stack built as a chain of cells
// The top of stack always sits in the first cell: push and pop shift the
// chain, and the top compare reads that cell. A fill count gives empty, single and full.
// ----------------------------------------------------------------------------
module bbc_stack #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bbc_pkg::stk_op_t   op,
  output bbc_pkg::stk_stat_t stat
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  bbc_pkg::kind_t   kinds [STACK_DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // Row of cells; inner ones see their two neighbors, the first takes the pushed kind, the last refills from itself.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    bbc_pkg::kind_t up_k;
    bbc_pkg::kind_t dn_k;
    if (i == 0) begin : g_first
      assign up_k = op.kind;
    end else begin : g_mid
      assign up_k = kinds[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign dn_k = kinds[i];
    end else begin : g_inner
      assign dn_k = kinds[i+1];
    end
    bbc_cell u_cell (
      .clk     (clk),
      .op      (op),
      .up_kind (up_k),
      .dn_kind (dn_k),
      .kind_q  (kinds[i])
    );
  end

  // Fill count; a clear wins over push and pop.
  always_comb begin
    count_nxt = count_r;
    if (op.clr) begin
      count_nxt = '0;
    end else if (op.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.empty  = (count_r == '0);
  assign stat.single = (count_r == CNT_W'(1));
  assign stat.full   = (count_r == CNT_W'(STACK_DEPTH));
  assign stat.top    = kinds[0];

endmodule
